FILE: rtl/core/lru_frame_replacement_core_macros.svh
// Assertion macros shared by the LRU frame replacement core modules.
`ifndef LRU_FRAME_REPLACEMENT_CORE_MACROS_SVH
`define LRU_FRAME_REPLACEMENT_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRUFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lrufr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LRUFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lrufr assertion failed");

`endif

FILE: rtl/core/lrufr_pkg.sv
// Shared types and constants of the LRU frame replacement core.
package lrufr_pkg;

   localparam int FRAME_W  = 4;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int FRAME_SPACE = 16;

   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TOUCH  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EVICT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EVICT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

FILE: rtl/core/lrufr_ctrl.sv
// Controller state machine of the LRU frame replacement core.
`include "lru_frame_replacement_core_macros.svh"

module lrufr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output lrufr_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_tready  = (state_ff == ST_IDLE);
   assign rsp_tvalid  = rsp_valid_ff;
   assign slot_free   = !rsp_valid_ff || rsp_tready;
   assign cmd.capture = req_tvalid && req_tready;
   assign cmd.execute = (state_ff == ST_EXEC) && slot_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd.execute) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The output register is never overwritten while its transaction is pending.
   `LRUFR_ASSERT_SAME(a_exec_slot_free, clock, reset, cmd.execute, slot_free)
   // A captured transaction is always followed by the execute state.
   `LRUFR_ASSERT_NEXT(a_capture_to_exec, clock, reset, cmd.capture, state_ff == ST_EXEC)

endmodule

FILE: rtl/core/lrufr_dp.sv
// Datapath of the LRU frame replacement core: recency order, held bits, result register.
`include "lru_frame_replacement_core_macros.svh"

module lrufr_dp #(
   parameter int FRAME_COUNT = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lrufr_pkg::cmd_type                  cmd,
   input  logic [lrufr_pkg::KIND_W-1:0]        req_kind,
   input  logic [lrufr_pkg::FRAME_W-1:0]       req_frame,
   output logic [lrufr_pkg::STATUS_W-1:0]      rsp_status,
   output logic                                rsp_was_held,
   output logic [lrufr_pkg::FRAME_W-1:0]       rsp_evicted_frame,
   output logic [lrufr_pkg::FRAME_W-1:0]       rsp_victim_frame,
   output logic                                rsp_victim_valid,
   output logic [lrufr_pkg::COUNT_W-1:0]       rsp_occupancy,
   output logic                                rsp_full_res
);

   localparam int DEPTH = (FRAME_COUNT < lrufr_pkg::FRAME_SPACE) ?
                          FRAME_COUNT : lrufr_pkg::FRAME_SPACE;
   localparam int FW = lrufr_pkg::FRAME_W;
   localparam int CW = lrufr_pkg::COUNT_W;

   // Registered transaction.
   logic [lrufr_pkg::KIND_W-1:0] kind_ff;
   logic [FW-1:0]                frame_ff;

   // Recency order, position 0 least recent; only positions below count_ff are live.
   logic [FW-1:0] order_ff [DEPTH];
   logic [FW-1:0] order_in [DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [lrufr_pkg::FRAME_SPACE-1:0] held_ff, held_in;

   // Result register.
   logic [lrufr_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                           was_ff, was_in;
   logic [FW-1:0]                  evicted_ff, evicted_in;
   logic [FW-1:0]                  victim_ff;
   logic                           victim_valid_ff;
   logic [CW-1:0]                  occ_ff;
   logic                           full_ff;

   logic            in_range;
   logic            held;
   logic [DEPTH-1:0] match;
   logic [CW-1:0]   match_pos;
   logic            drop;
   logic [CW-1:0]   drop_pos;
   logic            append;
   logic [CW-1:0]   count_mid;

   assign in_range = (32'(frame_ff) < FRAME_COUNT);
   assign held     = in_range && held_ff[frame_ff];

   // Associative search over the live positions.
   always_comb begin
      match_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         match[i] = (order_ff[i] == frame_ff) && (CW'(i) < count_ff);
         if (match[i]) match_pos = match_pos | CW'(i);
      end
   end

   // Operation decode: what leaves the order, what joins it, and the reported fields.
   always_comb begin
      drop       = 1'b0;
      drop_pos   = '0;
      append     = 1'b0;
      status_in  = lrufr_pkg::STATUS_OK;
      was_in     = 1'b0;
      evicted_in = '0;
      held_in    = held_ff;
      unique case (kind_ff)
         lrufr_pkg::KIND_INSERT: begin
            was_in = held;
            if (held) begin
               drop     = 1'b1;
               drop_pos = match_pos;
               append   = 1'b1;
            end else if (!in_range || (32'(count_ff) >= DEPTH)) begin
               status_in = lrufr_pkg::STATUS_FULL;
            end else begin
               append            = 1'b1;
               held_in[frame_ff] = 1'b1;
            end
         end
         lrufr_pkg::KIND_TOUCH: begin
            was_in = held;
            if (held) begin
               drop     = 1'b1;
               drop_pos = match_pos;
               append   = 1'b1;
            end
         end
         lrufr_pkg::KIND_EVICT: begin
            if (count_ff == '0) begin
               status_in = lrufr_pkg::STATUS_EVICT_EMPTY;
            end else begin
               drop                = 1'b1;
               evicted_in          = order_ff[0];
               held_in[order_ff[0]] = 1'b0;
            end
         end
         lrufr_pkg::KIND_REMOVE: begin
            was_in = held;
            if (held) begin
               drop              = 1'b1;
               drop_pos          = match_pos;
               held_in[frame_ff] = 1'b0;
            end else begin
               status_in = lrufr_pkg::STATUS_ABSENT;
            end
         end
         lrufr_pkg::KIND_CLEAR: begin
            held_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign count_mid = count_ff - CW'(drop);

   always_comb begin
      if (kind_ff == lrufr_pkg::KIND_CLEAR) begin
         count_in = '0;
      end else begin
         count_in = count_mid + CW'(append);
      end
   end

   // Each position either takes the new frame, closes the gap from above, or holds.
   for (genvar i = 0; i < DEPTH; i++) begin : g_pos
      if (i < DEPTH - 1) begin : g_shift
         always_comb begin
            if (append && (CW'(i) == count_mid)) begin
               order_in[i] = frame_ff;
            end else if (drop && (CW'(i) >= drop_pos) && (CW'(i + 1) < count_ff)) begin
               order_in[i] = order_ff[i+1];
            end else begin
               order_in[i] = order_ff[i];
            end
         end
      end else begin : g_top
         always_comb begin
            if (append && (CW'(i) == count_mid)) begin
               order_in[i] = frame_ff;
            end else begin
               order_in[i] = order_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         frame_ff <= req_frame;
      end
      if (cmd.execute) begin
         for (int i = 0; i < DEPTH; i++) begin
            order_ff[i] <= order_in[i];
         end
         status_ff       <= status_in;
         was_ff          <= was_in;
         evicted_ff      <= evicted_in;
         victim_ff       <= (count_in != '0) ? order_in[0] : '0;
         victim_valid_ff <= (count_in != '0);
         occ_ff          <= count_in;
         full_ff         <= (32'(count_in) == FRAME_COUNT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         held_ff  <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
         held_ff  <= held_in;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_was_held      = was_ff;
   assign rsp_evicted_frame = evicted_ff;
   assign rsp_victim_frame  = victim_ff;
   assign rsp_victim_valid  = victim_valid_ff;
   assign rsp_occupancy     = occ_ff;
   assign rsp_full_res      = full_ff;

   // Every live order position corresponds to exactly one held bit.
   `LRUFR_ASSERT_SAME(a_count_matches_held, clock, reset, 1'b1, $countones(held_ff) == 32'(count_ff))
   // The order never grows past its storage.
   `LRUFR_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, 32'(count_ff) <= DEPTH)

endmodule

FILE: rtl/core/lru_frame_replacement_core.sv
// Each transaction is first registered; then, in the execute state, the associative search
// over up to sixteen positions, the shift of the recency order and the held-bit update
// complete and load the response register. A new request is taken while the previous
// response still waits; the execute step stalls only while that response is not yet taken.
// Frame numbers at or above FRAME_COUNT are never held. No clearing pass follows reset.
module lru_frame_replacement_core #(
   parameter int FRAME_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] frame, [7:4] zero
   input  logic [2:0]  req_tuser,   // [2:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [2] was_held, [6:3] evicted_frame, [10:7] victim_frame,
   // [11] victim_valid, [16:12] occupancy, [17] full_res, [23:18] zero
   output logic [23:0] rsp_tdata
);

   lrufr_pkg::cmd_type                cmd;
   logic [lrufr_pkg::STATUS_W-1:0]    status;
   logic                              was_held;
   logic [lrufr_pkg::FRAME_W-1:0]     evicted_frame;
   logic [lrufr_pkg::FRAME_W-1:0]     victim_frame;
   logic                              victim_valid;
   logic [lrufr_pkg::COUNT_W-1:0]     occupancy;
   logic                              full_res;

   lrufr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lrufr_dp #(
      .FRAME_COUNT (FRAME_COUNT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_kind          (req_tuser),
      .req_frame         (req_tdata[3:0]),
      .rsp_status        (status),
      .rsp_was_held      (was_held),
      .rsp_evicted_frame (evicted_frame),
      .rsp_victim_frame  (victim_frame),
      .rsp_victim_valid  (victim_valid),
      .rsp_occupancy     (occupancy),
      .rsp_full_res      (full_res)
   );

   assign rsp_tdata = {6'b0, full_res, occupancy, victim_valid, victim_frame,
                       evicted_frame, was_held, status};

endmodule

FILE: bench/tb_lru_frame_replacement_core.sv
// Self-checking testbench for the LRU frame replacement core.
`timescale 1ns / 100ps

module tb_lru_frame_replacement_core;

   localparam int FRAME_SLOTS = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 1100;
   localparam int HOLD_CYCLES = 150;

   // One response, packed exactly as it sits in rsp_tdata[17:0].
   typedef struct packed {
      logic       full_res;
      logic [4:0] occupancy;
      logic       victim_valid;
      logic [3:0] victim_frame;
      logic [3:0] evicted_frame;
      logic       was_held;
      logic [1:0] status;
   } lru_result_type;

   class LruScoreboard;
      logic [3:0]     order[FRAME_SLOTS];
      logic [4:0]     held_total;
      bit             held[16];
      lru_result_type expected_q[$];
      int             errors;
      int             checked;
      int             kind_seen[5];
      int             status_seen[4];
      int             full_seen;

      function new();
         held_total = '0;
         foreach (held[i]) held[i] = 1'b0;
         foreach (order[i]) order[i] = '0;
         errors = 0;
         checked = 0;
         full_seen = 0;
         foreach (kind_seen[i]) kind_seen[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int position_of(logic [3:0] frame);
         for (int i = 0; i < held_total; i++)
            if (order[i] == frame) return i;
         return 0;
      endfunction

      // Close the gap left by the entry at pos.
      function void drop_at(int pos);
         if (held_total == 0 || pos >= held_total) return;
         for (int i = pos; i + 1 < held_total; i++) order[i] = order[i + 1];
         held_total = held_total - 1;
      endfunction

      function void make_recent(logic [3:0] frame);
         drop_at(position_of(frame));
         order[held_total] = frame;
         held_total = held_total + 1;
      endfunction

      function void note_request(logic [2:0] kind, logic [3:0] frame);
         lru_result_type r;
         bit             was;
         r = '0;
         was = (frame < FRAME_SLOTS) && held[frame];
         case (kind)
            lrufr_pkg::KIND_INSERT: begin
               r.was_held = was;
               if (was) begin
                  make_recent(frame);
               end else if (frame >= FRAME_SLOTS || held_total >= FRAME_SLOTS) begin
                  r.status = lrufr_pkg::STATUS_FULL;
               end else begin
                  order[held_total] = frame;
                  held_total = held_total + 1;
                  held[frame] = 1'b1;
               end
            end
            lrufr_pkg::KIND_TOUCH: begin
               r.was_held = was;
               if (was) make_recent(frame);
            end
            lrufr_pkg::KIND_EVICT: begin
               if (held_total == 0) begin
                  r.status = lrufr_pkg::STATUS_EVICT_EMPTY;
               end else begin
                  r.evicted_frame = order[0];
                  held[order[0]] = 1'b0;
                  drop_at(0);
               end
            end
            lrufr_pkg::KIND_REMOVE: begin
               r.was_held = was;
               if (was) begin
                  drop_at(position_of(frame));
                  held[frame] = 1'b0;
               end else begin
                  r.status = lrufr_pkg::STATUS_ABSENT;
               end
            end
            lrufr_pkg::KIND_CLEAR: begin
               held_total = '0;
               foreach (held[i]) held[i] = 1'b0;
            end
            default: ;
         endcase
         r.victim_frame = (held_total > 0) ? order[0] : 4'd0;
         r.victim_valid = (held_total > 0);
         r.occupancy    = held_total;
         r.full_res     = (held_total == FRAME_SLOTS);
         if (kind <= lrufr_pkg::KIND_CLEAR) kind_seen[kind]++;
         status_seen[r.status]++;
         if (r.full_res) full_seen++;
         expected_q = {expected_q, r};
      endfunction

      task report_mismatch(string what, int got, int want);
         errors++;
         $display("[%0t] response %0d: %s is %0d, expected %0d", $realtime, checked, what,
                  got, want);
      endtask

      task check_response(logic [23:0] data);
         lru_result_type got, want;
         got = lru_result_type'(data[17:0]);
         if (expected_q.size() == 0) begin
            report_mismatch("response with nothing outstanding, data", data, 0);
            return;
         end
         want = expected_q[0];
         expected_q.delete(0);
         if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
         if (got.was_held != want.was_held)
            report_mismatch("was_held", got.was_held, want.was_held);
         if (got.evicted_frame != want.evicted_frame)
            report_mismatch("evicted_frame", got.evicted_frame, want.evicted_frame);
         if (got.victim_frame != want.victim_frame)
            report_mismatch("victim_frame", got.victim_frame, want.victim_frame);
         if (got.victim_valid != want.victim_valid)
            report_mismatch("victim_valid", got.victim_valid, want.victim_valid);
         if (got.occupancy != want.occupancy)
            report_mismatch("occupancy", got.occupancy, want.occupancy);
         if (got.full_res != want.full_res)
            report_mismatch("full_res", got.full_res, want.full_res);
         checked++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;

   LruScoreboard frame_book;
   int           items_sent;
   bit           hold_done;

   lru_frame_replacement_core #(
      .FRAME_COUNT(FRAME_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idling is switched off for a stretch in the middle of the random part.
   function automatic bit quiet_window();
      return items_sent >= 700 && items_sent < 850;
   endfunction

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_lru_frame_replacement_core: done, errors");
      $finish;
   end

   // Both accepted transactions are sampled here, before this edge's updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) frame_book.check_response(rsp_tdata);
         if (req_tvalid && req_tready) frame_book.note_request(req_tuser, req_tdata[3:0]);
      end
   end

   // Receiver: random back-pressure plus one long hold-off that fills the block.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && items_sent >= 400) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (quiet_window()) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 26);
         end
      end
   end

   task automatic send_item(input logic [2:0] kind, input logic [3:0] frame);
      while (!quiet_window() && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0000, frame};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Draws one operation; the phase steers occupancy towards full or empty, or keeps a mix.
   task automatic send_random(input int phase);
      int          roll;
      logic [2:0]  kind;
      logic [3:0]  frame;
      roll = $urandom_range(99);
      case (phase)
         0: kind = roll < 60 ? lrufr_pkg::KIND_INSERT : roll < 80 ? lrufr_pkg::KIND_TOUCH :
                   roll < 88 ? lrufr_pkg::KIND_REMOVE : roll < 98 ? lrufr_pkg::KIND_EVICT :
                   lrufr_pkg::KIND_CLEAR;
         1: kind = roll < 15 ? lrufr_pkg::KIND_INSERT : roll < 30 ? lrufr_pkg::KIND_TOUCH :
                   roll < 60 ? lrufr_pkg::KIND_REMOVE : roll < 98 ? lrufr_pkg::KIND_EVICT :
                   lrufr_pkg::KIND_CLEAR;
         default: kind = roll < 35 ? lrufr_pkg::KIND_INSERT :
                   roll < 65 ? lrufr_pkg::KIND_TOUCH :
                   roll < 80 ? lrufr_pkg::KIND_REMOVE : roll < 98 ? lrufr_pkg::KIND_EVICT :
                   lrufr_pkg::KIND_CLEAR;
      endcase
      frame = 4'($urandom_range(15));
      // Aim touches and removals at held frames more often than chance would.
      if ((kind == lrufr_pkg::KIND_TOUCH || kind == lrufr_pkg::KIND_REMOVE) &&
          frame_book.held_total > 0 && $urandom_range(99) < 60)
         frame = frame_book.order[$urandom_range(frame_book.held_total - 1)];
      send_item(kind, frame);
   endtask

   initial begin : stimulus
      int phase;
      frame_book = new();
      items_sent = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = lrufr_pkg::KIND_INSERT;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-store cases, a duplicate insert, then fill to full, evict once and clear.
      send_item(lrufr_pkg::KIND_CLEAR, 4'd9);
      send_item(lrufr_pkg::KIND_EVICT, 4'd3);
      send_item(lrufr_pkg::KIND_REMOVE, 4'd15);
      send_item(lrufr_pkg::KIND_TOUCH, 4'd7);
      send_item(lrufr_pkg::KIND_INSERT, 4'd0);
      send_item(lrufr_pkg::KIND_INSERT, 4'd15);
      send_item(lrufr_pkg::KIND_INSERT, 4'd0);
      send_item(lrufr_pkg::KIND_TOUCH, 4'd15);
      send_item(lrufr_pkg::KIND_REMOVE, 4'd0);
      for (int f = 0; f < 15; f++) send_item(lrufr_pkg::KIND_INSERT, 4'(f));
      send_item(lrufr_pkg::KIND_EVICT, 4'd0);
      send_item(lrufr_pkg::KIND_CLEAR, 4'd15);

      phase = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) phase = $urandom_range(2);
         send_random(phase);
      end
      req_tvalid <= 1'b0;

      while (frame_book.pending() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d transactions: insert %0d, touch %0d, evict %0d, remove %0d",
               frame_book.checked, frame_book.kind_seen[lrufr_pkg::KIND_INSERT],
               frame_book.kind_seen[lrufr_pkg::KIND_TOUCH],
               frame_book.kind_seen[lrufr_pkg::KIND_EVICT],
               frame_book.kind_seen[lrufr_pkg::KIND_REMOVE]);
      $display("clear %0d, evict on empty %0d, remove of absent %0d, full responses %0d",
               frame_book.kind_seen[lrufr_pkg::KIND_CLEAR],
               frame_book.status_seen[lrufr_pkg::STATUS_EVICT_EMPTY],
               frame_book.status_seen[lrufr_pkg::STATUS_ABSENT],
               frame_book.full_seen);
      if (frame_book.errors == 0 && frame_book.pending() == 0) begin
         $display("tb_lru_frame_replacement_core: done, clean");
      end else begin
         $display("tb_lru_frame_replacement_core: done, errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/lrufr_pkg.sv
rtl/core/lrufr_ctrl.sv
rtl/core/lrufr_dp.sv
rtl/core/lru_frame_replacement_core.sv
bench/tb_lru_frame_replacement_core.sv
